[rtl/sorted_priority_queue_top_assert.svh]
// Assertion macros used by the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SPQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

[rtl/spq_pkg.sv]
// Types and constants of the sorted priority queue.
package spq_pkg;

  localparam int unsigned QueueDepthDef   = 64;
  localparam int unsigned PriorityBitsDef = 16;
  localparam int unsigned IdW             = 16;
  localparam int unsigned PrioFieldW      = 16;
  localparam int unsigned StatusW         = 2;
  localparam int unsigned CountW          = 7;

  typedef enum logic [StatusW-1:0] {
    StDone     = 2'd0,
    StFull     = 2'd1,
    StNotFound = 2'd2
  } status_e;

  typedef enum logic {
    OpInsert = 1'b0,
    OpRemove = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    SIdle,
    SWalk,
    STail,
    SHeadRd,
    SHeadWait
  } state_e;

endpackage

[rtl/spq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sorted_priority_queue_top.sv]
// Sorted priority queue: top level with walk sequencer and entry RAM.
//
// Requests come in on a valid/ready channel: opcode (insert or remove by id),
// priority and id. Each request gives exactly one response on a valid/ready
// output channel: status, head id and priority, empty flag and entry count.
// Entries live in one RAM kept sorted by descending priority; a new entry
// lands ahead of stored entries of equal priority.
// An insert or remove walks every held entry through the single RAM read
// port, one entry a cycle, then updates the tail and count and reads the
// head before responding. An insert into a full queue skips the walk.
// A new request is taken only after the previous response is loaded;
// in_ready_o is high only while the sequencer is idle.
// Reset empties the queue at once (count to zero; RAM contents are left as
// they are and never used before being written).
// The response sits in an output register; a stalled receiver does not stop
// the next request from being taken and walked, only its final response
// load waits until the previous response has been taken.
module sorted_priority_queue_top #(
  parameter int unsigned QueueDepth   = spq_pkg::QueueDepthDef,
  parameter int unsigned PriorityBits = spq_pkg::PriorityBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic [spq_pkg::PrioFieldW-1:0]   entry_priority_i,
  input  logic [spq_pkg::IdW-1:0]          entry_id_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [spq_pkg::StatusW-1:0]      status_o,
  output logic [spq_pkg::IdW-1:0]          head_id_o,
  output logic [spq_pkg::PrioFieldW-1:0]   head_priority_o,
  output logic                             is_empty_o,
  output logic [spq_pkg::CountW-1:0]       entry_count_o
);
  import spq_pkg::*;

  localparam int unsigned AddrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW   = $clog2(QueueDepth + 1);
  localparam int unsigned EntryW = PriorityBits + IdW;
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  state_e                  state_q, state_d;
  opcode_e                 op_q, op_d;
  status_e                 status_q, status_d;
  logic [PriorityBits-1:0] prio_q, prio_d;
  logic [IdW-1:0]          id_q, id_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]         iss_q, iss_d;
  logic                    pv_q, pv_d;
  logic [AddrW-1:0]        pidx_q, pidx_d;
  logic                    flag_q, flag_d;   // insert: placed; remove: found
  logic [EntryW-1:0]       carry_q, carry_d;

  logic                    out_valid_q, out_valid_d;
  status_e                 out_status_q, out_status_d;
  logic [IdW-1:0]          out_hid_q, out_hid_d;
  logic [PrioFieldW-1:0]   out_hprio_q, out_hprio_d;
  logic                    out_empty_q, out_empty_d;
  logic [CountW-1:0]       out_cnt_q, out_cnt_d;

  logic                    ram_we, ram_re;
  logic [AddrW-1:0]        ram_waddr, ram_raddr;
  logic [EntryW-1:0]       ram_wdata, ram_rdata;
  logic [PriorityBits-1:0] rd_prio;
  logic [IdW-1:0]          rd_id;

  logic [PriorityBits+PrioFieldW-1:0] in_prio_ext;
  logic [PriorityBits+PrioFieldW-1:0] hd_prio_ext;
  logic [CntW+CountW-1:0]             cnt_ext;
  logic [PriorityBits-1:0]            in_prio;

  assign rd_prio     = ram_rdata[EntryW-1:IdW];
  assign rd_id       = ram_rdata[IdW-1:0];
  assign in_prio_ext = {{PrioFieldW{1'b0}}, entry_priority_i};
  assign in_prio     = in_prio_ext[PriorityBits-1:0];
  assign hd_prio_ext = {{PrioFieldW{1'b0}}, rd_prio};
  assign cnt_ext     = {{CountW{1'b0}}, cnt_q};

  spq_ram #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_spq_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    status_d     = status_q;
    prio_d       = prio_q;
    id_d         = id_q;
    cnt_d        = cnt_q;
    iss_d        = iss_q;
    pv_d         = pv_q;
    pidx_d       = pidx_q;
    flag_d       = flag_q;
    carry_d      = carry_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_hid_d    = out_hid_q;
    out_hprio_d  = out_hprio_q;
    out_empty_d  = out_empty_q;
    out_cnt_d    = out_cnt_q;
    ram_we       = 1'b0;
    ram_waddr    = pidx_q;
    ram_wdata    = carry_q;
    ram_re       = 1'b0;
    ram_raddr    = iss_q[AddrW-1:0];
    in_ready_o   = 1'b0;

    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d     = opcode_e'(opcode_i);
          prio_d   = in_prio;
          id_d     = entry_id_i;
          iss_d    = '0;
          pv_d     = 1'b0;
          flag_d   = 1'b0;
          carry_d  = {in_prio, entry_id_i};
          status_d = StDone;
          if (opcode_e'(opcode_i) == OpInsert && cnt_q == FullCnt) begin
            status_d = StFull;
            state_d  = SHeadRd;
          end else begin
            state_d = SWalk;
          end
        end
      end

      SWalk: begin
        // read one entry ahead, act on the entry read last cycle
        if (iss_q != cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = iss_q[AddrW-1:0];
          iss_d     = iss_q + CntW'(1);
          pv_d      = 1'b1;
          pidx_d    = iss_q[AddrW-1:0];
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q) begin
          if (op_q == OpInsert) begin
            // once placed, every later entry moves down one slot
            if (flag_q || prio_q >= rd_prio) begin
              ram_we    = 1'b1;
              ram_waddr = pidx_q;
              ram_wdata = carry_q;
              carry_d   = ram_rdata;
              flag_d    = 1'b1;
            end
          end else begin
            if (flag_q) begin
              ram_we    = 1'b1;
              ram_waddr = pidx_q - AddrW'(1);
              ram_wdata = ram_rdata;
            end else if (rd_id == id_q) begin
              flag_d = 1'b1;
            end
          end
        end
        if (iss_q == cnt_q && !pv_q) begin
          state_d = STail;
        end
      end

      STail: begin
        if (op_q == OpInsert) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q[AddrW-1:0];
          ram_wdata = carry_q;
          cnt_d     = cnt_q + CntW'(1);
        end else if (flag_q) begin
          cnt_d = cnt_q - CntW'(1);
        end else begin
          status_d = StNotFound;
        end
        state_d = SHeadRd;
      end

      SHeadRd: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_d   = SHeadWait;
      end

      SHeadWait: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_cnt_d    = cnt_ext[CountW-1:0];
          if (cnt_q == '0) begin
            out_hid_d   = '0;
            out_hprio_d = '0;
            out_empty_d = 1'b1;
          end else begin
            out_hid_d   = rd_id;
            out_hprio_d = hd_prio_ext[PrioFieldW-1:0];
            out_empty_d = 1'b0;
          end
          state_d = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      iss_q       <= '0;
      pv_q        <= 1'b0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      iss_q       <= iss_d;
      pv_q        <= pv_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    status_q     <= status_d;
    prio_q       <= prio_d;
    id_q         <= id_d;
    pidx_q       <= pidx_d;
    carry_q      <= carry_d;
    out_status_q <= out_status_d;
    out_hid_q    <= out_hid_d;
    out_hprio_q  <= out_hprio_d;
    out_empty_q  <= out_empty_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign head_id_o       = out_hid_q;
  assign head_priority_o = out_hprio_q;
  assign is_empty_o      = out_empty_q;
  assign entry_count_o   = out_cnt_q;

endmodule

[rtl/spq_checker.sv]
// Port-level assertions for the sorted priority queue, bound to the top level.
`include "sorted_priority_queue_top_assert.svh"

module spq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [spq_pkg::StatusW-1:0]    status_o,
  input logic [spq_pkg::IdW-1:0]        head_id_o,
  input logic [spq_pkg::PrioFieldW-1:0] head_priority_o,
  input logic                           is_empty_o,
  input logic [spq_pkg::CountW-1:0]     entry_count_o
);
  import spq_pkg::*;

  logic all_zero;

  assign all_zero = entry_count_o == '0 && head_id_o == '0 && head_priority_o == '0;

  // a taken request keeps the block busy for at least the next cycle
  `SPQ_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o)

  // empty queue reports zeroed head and count
  `SPQ_ASSERT_IMPL(a_empty_zero, out_valid_o && is_empty_o, all_zero)

  // a refused insert means the queue is full, so never empty
  `SPQ_ASSERT_IMPL(a_full_not_empty, out_valid_o && status_o == StFull, !is_empty_o)

  `SPQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(head_id_o))

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);

[tb/sv/tb_sorted_priority_queue_top.sv]
// Testbench for the sorted priority queue: directed, fill, backpressure and random requests.
module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam int Depth       = QueueDepthDef;
  localparam int DrainCycles = Depth + 16;

  typedef struct {
    status_e                 status;
    logic [IdW-1:0]          head_id;
    logic [PrioFieldW-1:0]   head_prio;
    logic                    is_empty;
    logic [CountW-1:0]       count;
  } queue_rsp_t;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  in_valid_i       = 1'b0;
  logic                  in_ready_o;
  logic                  opcode_i         = OpInsert;
  logic [PrioFieldW-1:0] entry_priority_i = '0;
  logic [IdW-1:0]        entry_id_i       = '0;
  logic                  out_valid_o;
  logic                  out_ready_i      = 1'b0;
  logic [StatusW-1:0]    status_o;
  logic [IdW-1:0]        head_id_o;
  logic [PrioFieldW-1:0] head_priority_o;
  logic                  is_empty_o;
  logic [CountW-1:0]     entry_count_o;

  sorted_priority_queue_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .entry_priority_i(entry_priority_i),
    .entry_id_i      (entry_id_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .head_id_o       (head_id_o),
    .head_priority_o (head_priority_o),
    .is_empty_o      (is_empty_o),
    .entry_count_o   (entry_count_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Mirror of the sorted store, updated when a request is accepted.
  logic [PrioFieldW-1:0] queue_prio [Depth];
  logic [IdW-1:0]        queue_id   [Depth];
  int                    held_entries = 0;

  queue_rsp_t pending_responses [$];
  queue_rsp_t want;
  int         fail_count      = 0;
  bit         idle_on         = 1'b1;
  int         rx_hold_request = 0;
  int         rx_hold_left    = 0;
  int         rx_stall_left   = 0;

  function automatic queue_rsp_t predict_queue_update(opcode_e op,
                                                      logic [PrioFieldW-1:0] prio,
                                                      logic [IdW-1:0] id);
    queue_rsp_t rsp;
    int pos;
    rsp.status = StDone;
    if (op == OpInsert) begin
      if (held_entries >= Depth) begin
        rsp.status = StFull;
      end else begin
        // lands ahead of the first entry with priority <= its own
        pos = held_entries;
        for (int k = 0; k < held_entries; k++)
          if (pos == held_entries && prio >= queue_prio[k]) pos = k;
        for (int k = held_entries; k > pos; k--) begin
          queue_prio[k] = queue_prio[k-1];
          queue_id[k]   = queue_id[k-1];
        end
        queue_prio[pos] = prio;
        queue_id[pos]   = id;
        held_entries++;
      end
    end else begin
      pos = -1;
      for (int k = 0; k < held_entries; k++)
        if (pos < 0 && queue_id[k] == id) pos = k;
      if (pos < 0) begin
        rsp.status = StNotFound;
      end else begin
        for (int k = pos; k + 1 < held_entries; k++) begin
          queue_prio[k] = queue_prio[k+1];
          queue_id[k]   = queue_id[k+1];
        end
        held_entries--;
      end
    end
    rsp.is_empty  = (held_entries == 0);
    rsp.head_id   = rsp.is_empty ? '0 : queue_id[0];
    rsp.head_prio = rsp.is_empty ? '0 : queue_prio[0];
    rsp.count     = CountW'(held_entries);
    return rsp;
  endfunction

  function automatic logic [PrioFieldW-1:0] random_priority();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return PrioFieldW'($urandom_range(0, 7));  // ties
      default: return PrioFieldW'($urandom());
    endcase
  endfunction

  function automatic logic [IdW-1:0] random_id();
    case ($urandom_range(0, 19))
      0:                 return '1;
      1, 2, 3, 4, 5, 6,
      7, 8, 9, 10:       return IdW'($urandom_range(0, 15));  // duplicates
      default:           return IdW'($urandom());
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back requests never toggle it.
  task automatic send_request(opcode_e op, logic [PrioFieldW-1:0] prio,
                              logic [IdW-1:0] id);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= op;
    entry_priority_i <= prio;
    entry_id_i       <= id;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    pending_responses.push_back(predict_queue_update(op, prio, id));
    @(negedge clk_i);
  endtask

  task automatic send_random_request(int insert_pct);
    logic [IdW-1:0] id;
    if ($urandom_range(0, 99) < insert_pct) begin
      send_request(OpInsert, random_priority(), random_id());
    end else begin
      if (held_entries > 0 && $urandom_range(0, 99) < 85)
        id = queue_id[$urandom_range(0, held_entries - 1)];
      else
        id = random_id();
      send_request(OpRemove, random_priority(), id);
    end
  endtask

  task automatic test_directed();
    send_request(OpRemove, 16'h0000, 16'h0000);  // remove on empty
    send_request(OpRemove, 16'hffff, 16'hffff);
    send_request(OpInsert, 16'h0000, 16'h0000);
    send_request(OpInsert, 16'hffff, 16'hffff);
    send_request(OpInsert, 16'hffff, 16'h0001);  // equal priority goes first
    send_request(OpInsert, 16'h0000, 16'h0002);
    send_request(OpInsert, 16'h8000, 16'haaaa);
    send_request(OpInsert, 16'h7fff, 16'h5555);
    send_request(OpInsert, 16'h7fff, 16'haaaa);  // duplicate id
    send_request(OpRemove, 16'h0000, 16'haaaa);  // only the copy nearest head
    send_request(OpRemove, 16'h1234, 16'h4242);  // unknown id
    send_request(OpRemove, 16'hffff, 16'h0001);
    send_request(OpRemove, 16'h0000, 16'h0002);
    send_request(OpRemove, 16'h5a5a, 16'hffff);
    send_request(OpRemove, 16'ha5a5, 16'haaaa);
    send_request(OpRemove, 16'h0000, 16'h5555);
    send_request(OpRemove, 16'h0000, 16'h0000);
    send_request(OpRemove, 16'h0000, 16'h0000);
  endtask

  task automatic test_fill_and_empty();
    while (held_entries < Depth)
      send_request(OpInsert, random_priority(), random_id());
    repeat (3) send_request(OpInsert, random_priority(), random_id());  // refused
    send_request(OpRemove, random_priority(), 16'hbeef);
    while (held_entries > 0)
      send_request(OpRemove, random_priority(),
                   queue_id[$urandom_range(0, held_entries - 1)]);
  endtask

  task automatic test_backpressure();
    rx_hold_request = 400;
    repeat (12) send_random_request(70);
  endtask

  task automatic test_random_traffic();
    int insert_mix [5] = '{75, 50, 25, 90, 10};
    for (int n = 0; n < 1000; n++)
      send_random_request(insert_mix[(n / 100) % 5]);
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    repeat (150) send_random_request(50);
  endtask

  task automatic check_field(string name, logic [15:0] expv, logic [15:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expv, actv);
      fail_count++;
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_request > 0) begin
      rx_hold_left    = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_stall_left = $urandom_range(0, 8);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_responses.size() == 0) begin
        $error("response with no request outstanding");
        fail_count++;
      end else begin
        want = pending_responses.pop_front();
        check_field("status", 16'(want.status), 16'(status_o));
        check_field("head_id", want.head_id, head_id_o);
        check_field("head_priority", want.head_prio, head_priority_o);
        check_field("is_empty", 16'(want.is_empty), 16'(is_empty_o));
        check_field("entry_count", 16'(want.count), 16'(entry_count_o));
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_fill_and_empty();
    test_backpressure();
    test_random_traffic();
    test_no_idle();
    in_valid_i <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
